// ===== rtl/vsn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the voxel surface normal shader.
package vsn_pkg;

  localparam int NUM_COMP = 5;
  localparam int NORM_W = 16;
  localparam int MAG_W = 128;
  localparam int SQ_W = 256;
  localparam int ACC_W = 290;
  localparam int RHS_SHIFT = 30;
  localparam int LATENCY = 29;
  localparam int SIDE_DELAY = 20;

  localparam logic [1:0] DIM_PLANE = 2'd2;
  localparam logic [1:0] DIM_RESET = 2'd3;
  localparam logic [30:0] SIZE_RESET = 31'd65536;
  localparam logic [30:0] PLANE_WEIGHT = 31'd100;
  localparam logic [7:0] ALPHA_PLANE = 8'd255;
  localparam logic [7:0] ALPHA_VOLUME = 8'd100;

  typedef enum logic [2:0] {
    REG_DIMENSIONS = 3'd0,
    REG_COMPONENT_SELECT = 3'd1,
    REG_CELL_SIZE_X = 3'd2,
    REG_CELL_SIZE_Y = 3'd3,
    REG_CELL_SIZE_Z = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    COMP_X = 3'd0,
    COMP_Y = 3'd1,
    COMP_Z = 3'd2,
    COMP_W = 3'd3,
    COMP_T = 3'd4
  } comp_sel_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] value_corner;
    logic signed [31:0] value_step_x;
    logic signed [31:0] value_step_y;
    logic signed [31:0] value_step_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] norm_w;
    logic signed [15:0] norm_t;
    logic [7:0] gray_level;
    logic magenta_tint;
    logic [7:0] alpha;
  } out_item_t;

  typedef struct packed {
    logic magenta;
    logic x_neg;
    logic y_neg;
    logic z_neg;
    logic v0_neg;
    logic d1_neg;
    logic d2_neg;
    logic d3_neg;
  } in_sign_t;

  typedef struct packed {
    logic magenta;
    logic [NUM_COMP-1:0] neg;
  } comp_sign_t;

  typedef logic [ACC_W-1:0] acc_t;
  typedef acc_t [NUM_COMP-1:0] acc_vec_t;
  typedef logic [NUM_COMP-1:0][NORM_W-1:0] norm_vec_t;

endpackage

// ===== rtl/vsn_dly.sv =====
`timescale 1ns / 1ps
// Enabled delay line that keeps side data aligned with the arithmetic stages.
module vsn_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         ena,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [D];

  always_ff @(posedge clk) begin
    if (ena) begin
      line[0] <= d;
      for (int i = 1; i < D; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[D-1];

endmodule

// ===== rtl/vsn_umul.sv =====
`timescale 1ns / 1ps
// Three-stage unsigned multiplier built from registered 32x32 partial products.
module vsn_umul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic            clk,
  input  logic            ena,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] y
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int PW = 32 * (NA + NB);

  logic [NA*32-1:0] a_pad;
  logic [NB*32-1:0] b_pad;
  logic [63:0] pp [NA][NB];
  logic [PW-1:0] row [NA];
  logic [PW-1:0] row_next [NA];
  logic [PW-1:0] sum_next;

  assign a_pad = (NA*32)'(a);
  assign b_pad = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (ena) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= a_pad[32*i +: 32] * b_pad[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) << (32*j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      row <= row_next;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NA; i++) begin
      sum_next = sum_next + (row[i] << (32*i));
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      y <= sum_next[WA+WB-1:0];
    end
  end

endmodule

// ===== rtl/vsn_nstep.sv =====
`timescale 1ns / 1ps
// One bit of the normalizing root search for all components, registered.
module vsn_nstep #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               ena,
  input  vsn_pkg::acc_t      s_in,
  input  vsn_pkg::acc_vec_t  r_in,
  input  vsn_pkg::acc_vec_t  p_in,
  input  vsn_pkg::norm_vec_t n_in,
  output vsn_pkg::acc_t      s_out,
  output vsn_pkg::acc_vec_t  r_out,
  output vsn_pkg::acc_vec_t  p_out,
  output vsn_pkg::norm_vec_t n_out
);

  import vsn_pkg::*;

  acc_vec_t delta;
  logic [NUM_COMP-1:0] take;
  acc_t s_lin;
  acc_t s_sq;

  // Residual holds 2^30*c^2 - n^2*S and P holds n*S, so trying bit K needs only shifts.
  always_comb begin
    s_lin = s_in << K;
    s_sq = s_in << (2*K);
    for (int i = 0; i < NUM_COMP; i++) begin
      delta[i] = (p_in[i] << (K+1)) + s_sq;
      take[i] = (r_in[i] >= delta[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      s_out <= s_in;
      for (int i = 0; i < NUM_COMP; i++) begin
        r_out[i] <= take[i] ? (r_in[i] - delta[i]) : r_in[i];
        p_out[i] <= take[i] ? (p_in[i] + s_lin) : p_in[i];
        n_out[i] <= take[i] ? (n_in[i] | (NORM_W'(1) << K)) : n_in[i];
      end
    end
  end

endmodule

// ===== rtl/voxel_surface_normal_shader.sv =====
`timescale 1ns / 1ps
// Top level of the voxel surface normal shader pipeline.
//
// One request on the input channel carries a cell corner and the function
// values at the corner and one cell along each axis. For every request the
// block returns exactly one result on the output channel: five normalized
// Q1.15 components, a gray level for the selected component, a magenta flag
// and an alpha value. Both channels use valid and ready.
// The block is 29 register stages deep, and one request can be taken in
// every cycle while the output is not stalled. The depth is set by the
// chained 32x32 partial-product multipliers, the squaring stage and the
// sixteen one-bit stages of the normalizing root search.
// When the receiver holds ready low while a result is waiting, the whole
// pipeline freezes and input ready drops in the same cycle; nothing is lost
// or repeated. Reset empties the pipeline and loads the registers with
// volume mode, component x and unit cell sizes.
// Registers are written through the write port and must only change while
// no request is in flight.
module voxel_surface_normal_shader (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vsn_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vsn_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [30:0]          cfg_data
);

  import vsn_pkg::*;

  logic [1:0] dimensions;
  logic [2:0] comp_sel;
  logic [30:0] size_x;
  logic [30:0] size_y;
  logic [30:0] size_z;
  logic plane;
  logic [30:0] fz;
  logic [30:0] gz;

  logic ena;
  logic [LATENCY-1:0] vld;

  logic signed [32:0] d1_next;
  logic signed [32:0] d2_next;
  logic signed [32:0] d3_next;
  in_sign_t sign_next;
  in_sign_t sign1;
  in_sign_t sign_l3;
  logic [31:0] xm, ym, zm, v0m, d1m, d2m, d3m;
  logic [95:0] dm_dly;
  logic [31:0] d3e;

  logic [61:0] a1, a2, a3, b1, b2;
  logic [63:0] m1, m2, m3;
  logic [62:0] m4;
  logic [93:0] xp, yp, zp;
  logic [92:0] wp;
  logic [125:0] t1p, t2p, t3p;
  logic [124:0] t4p;

  logic signed [129:0] term [4];
  logic signed [129:0] tsum;
  logic [MAG_W-1:0] tmag;
  logic [MAG_W-1:0] cm [NUM_COMP];
  comp_sign_t csign;
  comp_sign_t csign_out;
  logic [SQ_W-1:0] sq [NUM_COMP];

  acc_t s_st [NORM_W+1];
  acc_vec_t r_st [NORM_W];
  acc_vec_t p_st [NORM_W];
  norm_vec_t n_st [NORM_W+1];

  logic zero_len;
  logic signed [16:0] ns [NUM_COMP];
  logic [15:0] nsat [NUM_COMP];
  logic [16:0] gsel;
  logic [24:0] gprod;
  logic [7:0] gray;

  assign plane = (dimensions == DIM_PLANE);
  assign fz = plane ? PLANE_WEIGHT : size_z;
  assign gz = plane ? 31'd1 : size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= DIM_RESET;
      comp_sel <= COMP_X;
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIMENSIONS: dimensions <= cfg_data[1:0];
        REG_COMPONENT_SELECT: comp_sel <= cfg_data[2:0];
        REG_CELL_SIZE_X: size_x <= cfg_data;
        REG_CELL_SIZE_Y: size_y <= cfg_data;
        REG_CELL_SIZE_Z: size_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign ena = !out_valid || out_ready;
  assign in_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ena) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  assign out_valid = vld[LATENCY-1];

  // Input stage: differences, magnitudes and signs.
  always_comb begin
    d1_next = {in_data.value_step_x[31], in_data.value_step_x}
            - {in_data.value_corner[31], in_data.value_corner};
    d2_next = {in_data.value_step_y[31], in_data.value_step_y}
            - {in_data.value_corner[31], in_data.value_corner};
    d3_next = {in_data.value_step_z[31], in_data.value_step_z}
            - {in_data.value_corner[31], in_data.value_corner};
    sign_next.x_neg = in_data.pos_x[31];
    sign_next.y_neg = in_data.pos_y[31];
    sign_next.z_neg = in_data.pos_z[31];
    sign_next.v0_neg = in_data.value_corner[31];
    sign_next.d1_neg = d1_next[32];
    sign_next.d2_neg = d2_next[32];
    sign_next.d3_neg = d3_next[32];
    sign_next.magenta = (2'(!in_data.value_corner[31]) + 2'(!in_data.value_step_x[31])
                       + 2'(!in_data.value_step_y[31])) < 2'd2;
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      sign1 <= sign_next;
      xm <= in_data.pos_x[31] ? (32'd0 - in_data.pos_x) : in_data.pos_x;
      ym <= in_data.pos_y[31] ? (32'd0 - in_data.pos_y) : in_data.pos_y;
      zm <= plane ? 32'd0 :
            (in_data.pos_z[31] ? (32'd0 - in_data.pos_z) : in_data.pos_z);
      v0m <= in_data.value_corner[31] ? (32'd0 - in_data.value_corner)
                                      : in_data.value_corner;
      d1m <= 32'(d1_next[32] ? -d1_next : d1_next);
      d2m <= 32'(d2_next[32] ? -d2_next : d2_next);
      d3m <= 32'(d3_next[32] ? -d3_next : d3_next);
    end
  end

  // First multiplier level.
  vsn_umul #(.WA(31), .WB(31)) u_a1 (.clk, .ena, .a(size_y), .b(fz), .y(a1));
  vsn_umul #(.WA(31), .WB(31)) u_a2 (.clk, .ena, .a(size_x), .b(fz), .y(a2));
  vsn_umul #(.WA(31), .WB(31)) u_a3 (.clk, .ena, .a(size_x), .b(size_y), .y(a3));
  vsn_umul #(.WA(31), .WB(31)) u_b1 (.clk, .ena, .a(size_y), .b(gz), .y(b1));
  vsn_umul #(.WA(31), .WB(31)) u_b2 (.clk, .ena, .a(size_x), .b(gz), .y(b2));
  vsn_umul #(.WA(32), .WB(32)) u_m1 (.clk, .ena, .a(xm), .b(d1m), .y(m1));
  vsn_umul #(.WA(32), .WB(32)) u_m2 (.clk, .ena, .a(ym), .b(d2m), .y(m2));
  vsn_umul #(.WA(32), .WB(32)) u_m3 (.clk, .ena, .a(zm), .b(d3m), .y(m3));
  vsn_umul #(.WA(32), .WB(31)) u_m4 (.clk, .ena, .a(v0m), .b(gz), .y(m4));

  vsn_dly #(.W(96), .D(3)) u_dm_dly (.clk, .ena, .d({d1m, d2m, d3m}), .q(dm_dly));

  assign d3e = plane ? 32'd1 : dm_dly[31:0];

  // Second multiplier level.
  vsn_umul #(.WA(62), .WB(32)) u_xp (.clk, .ena, .a(a1), .b(dm_dly[95:64]), .y(xp));
  vsn_umul #(.WA(62), .WB(32)) u_yp (.clk, .ena, .a(a2), .b(dm_dly[63:32]), .y(yp));
  vsn_umul #(.WA(62), .WB(32)) u_zp (.clk, .ena, .a(a3), .b(d3e), .y(zp));
  vsn_umul #(.WA(62), .WB(31)) u_wp (.clk, .ena, .a(a3), .b(size_z), .y(wp));
  vsn_umul #(.WA(64), .WB(62)) u_t1 (.clk, .ena, .a(m1), .b(b1), .y(t1p));
  vsn_umul #(.WA(64), .WB(62)) u_t2 (.clk, .ena, .a(m2), .b(b2), .y(t2p));
  vsn_umul #(.WA(64), .WB(62)) u_t3 (.clk, .ena, .a(m3), .b(a3), .y(t3p));
  vsn_umul #(.WA(63), .WB(62)) u_t4 (.clk, .ena, .a(m4), .b(a3), .y(t4p));

  vsn_dly #(.W($bits(in_sign_t)), .D(6)) u_sign_dly (
    .clk, .ena, .d(sign1), .q(sign_l3)
  );

  // Component assembly: signed sum for the offset term, signs of all components.
  always_comb begin
    term[0] = (sign_l3.x_neg ^ sign_l3.d1_neg) ? (130'd0 - 130'(t1p)) : 130'(t1p);
    term[1] = (sign_l3.y_neg ^ sign_l3.d2_neg) ? (130'd0 - 130'(t2p)) : 130'(t2p);
    term[2] = (sign_l3.z_neg ^ sign_l3.d3_neg) ? (130'd0 - 130'(t3p)) : 130'(t3p);
    term[3] = sign_l3.v0_neg ? 130'(t4p) : (130'd0 - 130'(t4p));
    tsum = term[0] + term[1] + term[2] + term[3];
    tmag = MAG_W'(tsum[129] ? -tsum : tsum);
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      cm[0] <= MAG_W'({xp, 16'h0});
      cm[1] <= MAG_W'({yp, 16'h0});
      cm[2] <= MAG_W'({zp, 16'h0});
      cm[3] <= plane ? tmag : MAG_W'({wp, 16'h0});
      cm[4] <= tmag;
      csign.magenta <= sign_l3.magenta;
      csign.neg[0] <= plane ? sign_l3.d1_neg : !sign_l3.d1_neg;
      csign.neg[1] <= !sign_l3.d2_neg;
      csign.neg[2] <= plane ? 1'b0 : sign_l3.d3_neg;
      csign.neg[3] <= plane ? tsum[129] : 1'b1;
      csign.neg[4] <= tsum[129];
    end
  end

  vsn_dly #(.W($bits(comp_sign_t)), .D(SIDE_DELAY)) u_csign_dly (
    .clk, .ena, .d(csign), .q(csign_out)
  );

  for (genvar g = 0; g < NUM_COMP; g++) begin : g_sq
    vsn_umul #(.WA(MAG_W), .WB(MAG_W)) u_sq (
      .clk, .ena, .a(cm[g]), .b(cm[g]), .y(sq[g])
    );
  end

  // Squared length; in plane mode the offset term is counted once, as w.
  always_ff @(posedge clk) begin
    if (ena) begin
      s_st[0] <= ACC_W'(sq[0]) + ACC_W'(sq[1]) + ACC_W'(sq[2]) + ACC_W'(sq[3])
               + (plane ? '0 : ACC_W'(sq[4]));
      for (int i = 0; i < NUM_COMP; i++) begin
        r_st[0][i] <= ACC_W'(sq[i]) << RHS_SHIFT;
      end
    end
  end

  assign p_st[0] = '0;
  assign n_st[0] = '0;

  for (genvar g = 0; g < NORM_W; g++) begin : g_step
    if (g < NORM_W - 1) begin : g_mid
      vsn_nstep #(.K(NORM_W - 1 - g)) u_step (
        .clk, .ena,
        .s_in(s_st[g]), .r_in(r_st[g]), .p_in(p_st[g]), .n_in(n_st[g]),
        .s_out(s_st[g+1]), .r_out(r_st[g+1]), .p_out(p_st[g+1]), .n_out(n_st[g+1])
      );
    end else begin : g_last
      vsn_nstep #(.K(0)) u_step (
        .clk, .ena,
        .s_in(s_st[g]), .r_in(r_st[g]), .p_in(p_st[g]), .n_in(n_st[g]),
        .s_out(s_st[g+1]), .r_out(), .p_out(), .n_out(n_st[g+1])
      );
    end
  end

  // Output stage: sign, saturation and gray level.
  always_comb begin
    zero_len = (s_st[NORM_W] == '0);
    for (int i = 0; i < NUM_COMP; i++) begin
      ns[i] = zero_len ? 17'sd0 :
              (csign_out.neg[i] ? (17'sd0 - {1'b0, n_st[NORM_W][i]})
                                : {1'b0, n_st[NORM_W][i]});
      nsat[i] = (!ns[i][16] && ns[i][15]) ? 16'h7FFF : ns[i][15:0];
    end
    case (comp_sel)
      COMP_X: gsel = 17'(ns[0]) + 17'd32768;
      COMP_Y: gsel = 17'(ns[1]) + 17'd32768;
      COMP_Z: gsel = 17'(ns[2]) + 17'd32768;
      COMP_W: gsel = 17'(ns[3]) + 17'd32768;
      COMP_T: gsel = 17'(ns[4]) + 17'd32768;
      default: gsel = 17'd0;
    endcase
    gprod = 25'(gsel) * 25'd255;
    gray = (comp_sel > COMP_T) ? 8'd0 : gprod[23:16];
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      out_data.norm_x <= nsat[0];
      out_data.norm_y <= nsat[1];
      out_data.norm_z <= nsat[2];
      out_data.norm_w <= nsat[3];
      out_data.norm_t <= nsat[4];
      out_data.gray_level <= gray;
      out_data.magenta_tint <= plane && csign_out.magenta;
      out_data.alpha <= plane ? ALPHA_PLANE : ALPHA_VOLUME;
    end
  end

  a_magenta_plane : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.magenta_tint |-> out_data.alpha == ALPHA_PLANE)
    else $error("Magenta tint given outside plane mode.");

  a_plane_wt : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.alpha == ALPHA_PLANE |-> out_data.norm_w == out_data.norm_t)
    else $error("Plane mode result with differing w and t components.");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result offered right after reset.");

endmodule

// ===== tb/voxel_surface_normal_shader_checker.sv =====
`timescale 1ns / 1ps
// Checker for the voxel surface normal shader: predicts each result and compares it.
module voxel_surface_normal_shader_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  vsn_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  vsn_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 cells_checked
);

  import vsn_pkg::*;

  typedef logic signed [143:0] term_t;
  typedef logic [319:0] wide_t;

  logic [1:0]  dims;
  logic [2:0]  sel;
  logic [30:0] size_x, size_y, size_z;
  out_item_t   shade_queue[$];

  function automatic out_item_t shade(in_item_t c);
    longint x, y, z, v0, v1, v2, d1, d2, d3, sx, sy, sz;
    term_t comp[NUM_COMP];
    wide_t mag, sum, rhs, lhs;
    int norm[NUM_COMP];
    int used, lo, hi, mid, nonneg, gray;
    logic plane;
    logic [15:0] sat[NUM_COMP];
    out_item_t r;
    x = c.pos_x;
    y = c.pos_y;
    z = c.pos_z;
    v0 = c.value_corner;
    v1 = c.value_step_x;
    v2 = c.value_step_y;
    d1 = v1 - v0;
    d2 = v2 - v0;
    d3 = longint'(c.value_step_z) - v0;
    sx = longint'(size_x);
    sy = longint'(size_y);
    sz = longint'(size_z);
    plane = (dims == DIM_PLANE);
    if (plane) begin
      comp[0] = term_t'(100) * term_t'(sy) * term_t'(d1) * term_t'(65536);
      comp[1] = term_t'(-100) * term_t'(sx) * term_t'(d2) * term_t'(65536);
      comp[2] = term_t'(sx) * term_t'(sy) * term_t'(65536);
      comp[3] = term_t'(x) * term_t'(sy) * term_t'(d1) + term_t'(y) * term_t'(sx) * term_t'(d2)
              - term_t'(v0) * term_t'(sx) * term_t'(sy);
      comp[4] = comp[3];
      used = 4;
    end else begin
      comp[0] = -(term_t'(sy) * term_t'(sz) * term_t'(d1) * term_t'(65536));
      comp[1] = -(term_t'(sx) * term_t'(sz) * term_t'(d2) * term_t'(65536));
      comp[2] = term_t'(sx) * term_t'(sy) * term_t'(d3) * term_t'(65536);
      comp[3] = -(term_t'(sx) * term_t'(sy) * term_t'(sz) * term_t'(65536));
      comp[4] = term_t'(x) * term_t'(sy) * term_t'(sz) * term_t'(d1)
              + term_t'(y) * term_t'(sx) * term_t'(sz) * term_t'(d2)
              + term_t'(z) * term_t'(sx) * term_t'(sy) * term_t'(d3)
              - term_t'(v0) * term_t'(sx) * term_t'(sy) * term_t'(sz);
      used = 5;
    end
    sum = '0;
    for (int i = 0; i < used; i++) begin
      mag = wide_t'(comp[i] < 0 ? -comp[i] : comp[i]);
      sum = sum + mag * mag;
    end
    for (int i = 0; i < NUM_COMP; i++) begin
      norm[i] = 0;
      if (sum != '0) begin
        mag = wide_t'(comp[i] < 0 ? -comp[i] : comp[i]);
        rhs = (mag * mag) << RHS_SHIFT;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          lhs = wide_t'(mid * mid) * sum;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        norm[i] = comp[i] < 0 ? -lo : lo;
      end
      sat[i] = norm[i] > 32767 ? 16'h7fff : norm[i][15:0];
    end
    gray = (sel <= COMP_T) ? (255 * (norm[sel] + 32768)) >>> 16 : 0;
    r.norm_x = sat[0];
    r.norm_y = sat[1];
    r.norm_z = sat[2];
    r.norm_w = sat[3];
    r.norm_t = sat[4];
    r.gray_level = gray[7:0];
    nonneg = (v0 >= 0) + (v1 >= 0) + (v2 >= 0);
    r.magenta_tint = plane && (nonneg < 2);
    r.alpha = plane ? ALPHA_PLANE : ALPHA_VOLUME;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic compare(out_item_t got, out_item_t want);
    if (got.norm_x !== want.norm_x) report("norm_x", got.norm_x, want.norm_x);
    if (got.norm_y !== want.norm_y) report("norm_y", got.norm_y, want.norm_y);
    if (got.norm_z !== want.norm_z) report("norm_z", got.norm_z, want.norm_z);
    if (got.norm_w !== want.norm_w) report("norm_w", got.norm_w, want.norm_w);
    if (got.norm_t !== want.norm_t) report("norm_t", got.norm_t, want.norm_t);
    if (got.gray_level !== want.gray_level)
      report("gray_level", got.gray_level, want.gray_level);
    if (got.magenta_tint !== want.magenta_tint)
      report("magenta_tint", got.magenta_tint, want.magenta_tint);
    if (got.alpha !== want.alpha) report("alpha", got.alpha, want.alpha);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    cells_checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      dims = DIM_RESET;
      sel = COMP_X;
      size_x = SIZE_RESET;
      size_y = SIZE_RESET;
      size_z = SIZE_RESET;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_DIMENSIONS: dims = cfg_data[1:0];
          REG_COMPONENT_SELECT: sel = cfg_data[2:0];
          REG_CELL_SIZE_X: size_x = cfg_data;
          REG_CELL_SIZE_Y: size_y = cfg_data;
          REG_CELL_SIZE_Z: size_z = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (shade_queue.size() == 0) begin
          $display("%0t ns: result with no request waiting", $time);
          errors++;
        end else begin
          compare(out_data, shade_queue.pop_front());
          cells_checked++;
        end
      end
      if (in_valid && in_ready) shade_queue.push_back(shade(in_data));
      pending = shade_queue.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the voxel surface normal shader testbench: stimulus, register setup and verdict.
module testbench;
  import vsn_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  int          errors, pending, cells_checked;
  int          cells_sent = 0;
  bit          calm = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  voxel_surface_normal_shader DUT (.*);

  voxel_surface_normal_shader_checker checker_i (.*);

  function automatic logic [31:0] sample_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(in_item_t req);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_data = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random();
    in_item_t c;
    logic [31:0] v0;
    v0 = sample_value();
    c.pos_x = sample_value();
    c.pos_y = sample_value();
    c.pos_z = sample_value();
    c.value_corner = v0;
    c.value_step_x = $urandom_range(0, 3) == 0 ? v0 : sample_value();
    c.value_step_y = $urandom_range(0, 3) == 0 ? v0 : sample_value();
    c.value_step_z = $urandom_range(0, 3) == 0 ? v0 : sample_value();
    send(c);
  endtask

  task automatic send_directed();
    logic [31:0] lo, hi;
    lo = 32'h8000_0000;
    hi = 32'h7fff_ffff;
    send('0);
    send({7{hi}});
    send({7{lo}});
    send({hi, lo, hi, lo, hi, lo, hi});
    send({lo, lo, lo, hi, lo, lo, lo});
    send({hi, hi, hi, lo, hi, hi, hi});
    send({32'h1_0000, 32'hffff_0000, 32'h2_0000, 32'hffff_ffff, 32'h0, 32'h1, 32'h5});
    send({32'h0, 32'h0, 32'h0, 32'h1_0000, 32'hffff_0000, 32'hffff_0000, 32'h0});
    send({32'h0, 32'h0, 32'h0, 32'hffff_0000, 32'h1_0000, 32'hffff_0000, 32'h0});
    send({32'h0, 32'h0, 32'h0, 32'hffff_0000, 32'hffff_0000, 32'h1_0000, 32'h3});
  endtask

  task automatic write_reg(reg_index_t idx, logic [30:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic setup(logic [1:0] d, logic [2:0] s, logic [30:0] sx, logic [30:0] sy,
                       logic [30:0] sz);
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
    write_reg(REG_DIMENSIONS, d);
    write_reg(REG_COMPONENT_SELECT, s);
    write_reg(REG_CELL_SIZE_X, sx);
    write_reg(REG_CELL_SIZE_Y, sy);
    write_reg(REG_CELL_SIZE_Z, sz);
  endtask

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(1, 16));
      1: return 31'h7fff_ffff;
      default: return 31'($urandom_range(1, 31'h7fff_ffff));
    endcase
  endfunction

  initial begin
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_directed();
    setup(DIM_PLANE, COMP_W, SIZE_RESET, SIZE_RESET, SIZE_RESET);
    send_directed();
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: setup(DIM_PLANE, COMP_X, 31'd1, 31'd1, 31'd1);
        1: setup(2'd3, COMP_Y, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
        2: setup(2'd0, COMP_T, rand_size(), rand_size(), rand_size());
        3: setup(2'd1, COMP_Z, rand_size(), rand_size(), rand_size());
        4: setup(DIM_PLANE, COMP_T, rand_size(), rand_size(), 31'd1);
        5: setup(2'd3, 3'd5, rand_size(), rand_size(), rand_size());
        6: setup(DIM_PLANE, 3'd7, rand_size(), rand_size(), rand_size());
        7: setup(2'd3, 3'd6, 31'd0, 31'd0, 31'd0);
        8: setup(DIM_PLANE, COMP_Y, 31'd0, rand_size(), rand_size());
        9: setup(2'd3, COMP_W, 31'd1, 31'h7fff_ffff, 31'd1);
        default: setup(phase[0] ? DIM_PLANE : 2'd3, 3'($urandom_range(0, 4)), rand_size(),
                       rand_size(), rand_size());
      endcase
      calm = (phase == 11);
      repeat (118) send_random();
    end
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d cells through 14 register settings, plane and volume modes,",
             cells_sent);
    $display("and %0d results were checked against the predictor.", cells_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
